@@ design/bcc_pkg.sv @@
// shared types and constants for the button click and hold classifier
`timescale 1ns / 1ps

package bcc_pkg;

   // saturation limit of the click counter
   localparam int MAX_CLICKS = 15;
   localparam int CLICK_W    = $clog2(MAX_CLICKS + 1);

   localparam int TIME_W   = 32;
   localparam int THRESH_W = 16;
   localparam int KIND_W   = 3;
   localparam int TOTAL_W  = 4;
   localparam int CSR_IDX_W = 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_HOLD  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EXTRA_HOLD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SUPER_HOLD = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CLICK_GAP  = 2'd3;

   // register reset values
   localparam logic [THRESH_W-1:0] LONG_HOLD_RESET  = 16'd1000;
   localparam logic [THRESH_W-1:0] EXTRA_HOLD_RESET = 16'd3000;
   localparam logic [THRESH_W-1:0] SUPER_HOLD_RESET = 16'd4000;
   localparam logic [THRESH_W-1:0] CLICK_GAP_RESET  = 16'd300;

   typedef enum logic [KIND_W-1:0] {
      EV_NONE  = 3'd0,
      EV_CLICK = 3'd1,
      EV_LONG  = 3'd2,
      EV_EXTRA = 3'd3,
      EV_SUPER = 3'd4
   } event_kind_type;

   typedef struct packed {
      logic [THRESH_W-1:0] long_hold_ms;
      logic [THRESH_W-1:0] extra_hold_ms;
      logic [THRESH_W-1:0] super_hold_ms;
      logic [THRESH_W-1:0] click_gap_ms;
   } cfg_type;

endpackage

@@ design/bcc_csr.sv @@
// configuration registers for the button click and hold classifier
`timescale 1ns / 1ps

module bcc_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [bcc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bcc_pkg::THRESH_W-1:0]  csr_write_data,
   output bcc_pkg::cfg_type              cfg
);
   import bcc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_LONG_HOLD:  cfg_in.long_hold_ms  = csr_write_data;
            CSR_EXTRA_HOLD: cfg_in.extra_hold_ms = csr_write_data;
            CSR_SUPER_HOLD: cfg_in.super_hold_ms = csr_write_data;
            CSR_CLICK_GAP:  cfg_in.click_gap_ms  = csr_write_data;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.long_hold_ms  <= LONG_HOLD_RESET;
         cfg_ff.extra_hold_ms <= EXTRA_HOLD_RESET;
         cfg_ff.super_hold_ms <= SUPER_HOLD_RESET;
         cfg_ff.click_gap_ms  <= CLICK_GAP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ design/bcc_core.sv @@
// press, hold and click state with the per-sample classification logic
`timescale 1ns / 1ps

module bcc_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic                        button_level,
   input  logic [bcc_pkg::TIME_W-1:0]  now_ms,
   input  bcc_pkg::cfg_type            cfg,
   output bcc_pkg::event_kind_type     event_kind,
   output logic [bcc_pkg::TOTAL_W-1:0] click_total
);
   import bcc_pkg::*;

   logic               prev_level_ff,    prev_level_in;
   logic [TIME_W-1:0]  press_start_ff,   press_start_in;
   logic [TIME_W-1:0]  release_stamp_ff, release_stamp_in;
   logic               long_done_ff,     long_done_in;
   logic               extra_done_ff,    extra_done_in;
   logic               super_done_ff,    super_done_in;
   logic [CLICK_W-1:0] click_counter_ff, click_counter_in;

   logic              press_edge;
   logic              release_edge;
   logic [TIME_W-1:0] held;
   logic [TIME_W-1:0] quiet;

   always_comb begin
      press_edge       = !button_level && prev_level_ff;
      press_start_in   = press_edge ? now_ms : press_start_ff;
      long_done_in     = press_edge ? 1'b0 : long_done_ff;
      extra_done_in    = press_edge ? 1'b0 : extra_done_ff;
      super_done_in    = press_edge ? 1'b0 : super_done_ff;
      release_stamp_in = release_stamp_ff;
      click_counter_in = click_counter_ff;
      prev_level_in    = button_level;
      event_kind       = EV_NONE;
      click_total      = '0;

      // hold tiers, highest first
      held = now_ms - press_start_in;
      if (!button_level) begin
         if (held > TIME_W'(cfg.super_hold_ms) && !super_done_in) begin
            super_done_in    = 1'b1;
            extra_done_in    = 1'b1;
            long_done_in     = 1'b1;
            click_counter_in = '0;
            event_kind       = EV_SUPER;
         end else if (held > TIME_W'(cfg.extra_hold_ms) && !extra_done_in) begin
            extra_done_in    = 1'b1;
            long_done_in     = 1'b1;
            click_counter_in = '0;
            event_kind       = EV_EXTRA;
         end else if (held > TIME_W'(cfg.long_hold_ms) && !long_done_in) begin
            long_done_in     = 1'b1;
            click_counter_in = '0;
            event_kind       = EV_LONG;
         end
      end

      // short release counts one click
      release_edge = button_level && !prev_level_ff && !long_done_in;
      if (release_edge) begin
         if (click_counter_in < CLICK_W'(MAX_CLICKS)) begin
            click_counter_in = click_counter_in + 1'b1;
         end
         release_stamp_in = now_ms;
      end

      // quiet gap closes the click run
      quiet = now_ms - release_stamp_in;
      if (click_counter_in != '0 && quiet > TIME_W'(cfg.click_gap_ms)) begin
         event_kind       = EV_CLICK;
         click_total      = TOTAL_W'(click_counter_in);
         click_counter_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_level_ff    <= 1'b1;
         press_start_ff   <= '0;
         release_stamp_ff <= '0;
         long_done_ff     <= 1'b0;
         extra_done_ff    <= 1'b0;
         super_done_ff    <= 1'b0;
         click_counter_ff <= '0;
      end else if (step) begin
         prev_level_ff    <= prev_level_in;
         press_start_ff   <= press_start_in;
         release_stamp_ff <= release_stamp_in;
         long_done_ff     <= long_done_in;
         extra_done_ff    <= extra_done_in;
         super_done_ff    <= super_done_in;
         click_counter_ff <= click_counter_in;
      end
   end

endmodule

@@ design/button_click_and_hold_classifier_unit.sv @@
// top level of the button click and hold classifier
`timescale 1ns / 1ps

// usage
// - req channel: one request per button sample, req_button_level (0 pressed,
//   1 released) with its millisecond timestamp req_now_ms
// - rsp channel: exactly one response per request, rsp_event_kind
//   (none, click run, long, extra long, super long) and rsp_click_total
// - csr port: four 16 bit thresholds written by index while the block is
//   idle, no read-back; each write replaces the whole selected threshold
// - path: a taken request is held in the request register, classified
//   combinationally from it, and its result is captured in the response
//   register once that register is free or being drained
// - throughput: one request per cycle while rsp_ready holds, set by the
//   single classification step between the request and response registers
// - a stalled response holds in the response register; the request register
//   still fills behind it, and req_ready drops only when both are full
// - reset (synchronous, active high) empties both registers, loads the
//   default thresholds and returns the classifier to released with no clicks
module button_click_and_hold_classifier_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_button_level,
   input  logic [bcc_pkg::TIME_W-1:0]    req_now_ms,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [bcc_pkg::KIND_W-1:0]    rsp_event_kind,
   output logic [bcc_pkg::TOTAL_W-1:0]   rsp_click_total,
   input  logic                          csr_write_enable,
   input  logic [bcc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bcc_pkg::THRESH_W-1:0]  csr_write_data
);
   import bcc_pkg::*;

   cfg_type cfg;

   // request register
   logic              req_valid_ff;
   logic              req_level_ff;
   logic [TIME_W-1:0] req_now_ff;

   // response register
   logic               rsp_valid_ff;
   event_kind_type     rsp_kind_ff;
   logic [TOTAL_W-1:0] rsp_total_ff;

   event_kind_type     core_kind;
   logic [TOTAL_W-1:0] core_total;

   logic advance;
   logic req_take;

   // request moves on when the response register is free or being drained
   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   bcc_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   // classifier state advances once per request leaving the request register
   bcc_core u_core (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .button_level (req_level_ff),
      .now_ms       (req_now_ff),
      .cfg          (cfg),
      .event_kind   (core_kind),
      .click_total  (core_total)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            req_valid_ff <= 1'b1;
         end else if (advance) begin
            req_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_level_ff <= req_button_level;
         req_now_ff   <= req_now_ms;
      end
      if (advance) begin
         rsp_kind_ff  <= core_kind;
         rsp_total_ff <= core_total;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event_kind  = rsp_kind_ff;
   assign rsp_click_total = rsp_total_ff;

endmodule

@@ tb/button_click_and_hold_classifier_unit_tb.sv @@
// self-checking testbench for the button click and hold classifier
`timescale 1ns / 1ps

module button_click_and_hold_classifier_unit_tb;
   import bcc_pkg::*;

   // random part stops after about this many requests, spread over the phases
   localparam int SAMPLE_TARGET = 1950;
   localparam int PHASE_COUNT   = 8;
   localparam int TABLE_ROWS    = 19;

   typedef struct packed {
      event_kind_type     kind;
      logic [TOTAL_W-1:0] total;
   } button_event_type;

   // one row of the directed table; typed rows carry their own expected event
   typedef struct packed {
      logic               level;
      logic [TIME_W-1:0]  now;
      logic               typed;
      event_kind_type     kind;
      logic [TOTAL_W-1:0] total;
   } sample_row_type;

   logic                 clock            = 1'b0;
   logic                 reset            = 1'b1;
   logic                 req_valid        = 1'b0;
   logic                 req_ready;
   logic                 req_button_level = 1'b1;
   logic [TIME_W-1:0]    req_now_ms       = '0;
   logic                 rsp_valid;
   logic                 rsp_ready        = 1'b0;
   logic [KIND_W-1:0]    rsp_event_kind;
   logic [TOTAL_W-1:0]   rsp_click_total;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index        = CSR_LONG_HOLD;
   logic [THRESH_W-1:0]  csr_write_data   = '0;

   // idling knobs, percent of cycles
   int unsigned send_idle_pct = 0;
   int unsigned stall_pct     = 0;

   int error_count  = 0;
   int samples_sent = 0;

   // events predicted for accepted requests, oldest first
   button_event_type expected_events [$];

   // shadow of the classifier state and thresholds
   cfg_type           thr = '{LONG_HOLD_RESET, EXTRA_HOLD_RESET, SUPER_HOLD_RESET,
                              CLICK_GAP_RESET};
   logic              btn_released   = 1'b1;
   logic [TIME_W-1:0] press_t        = '0;
   logic [TIME_W-1:0] release_t      = '0;
   logic              long_seen      = 1'b0;
   logic              extra_seen     = 1'b0;
   logic              super_seen     = 1'b0;
   int unsigned       pending_clicks = 0;

   // time cursor of the random button episodes
   logic [TIME_W-1:0] stamp_ms = '0;

   button_click_and_hold_classifier_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_button_level (req_button_level),
      .req_now_ms       (req_now_ms),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_click_total  (rsp_click_total),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // classify one sample and advance the shadow state
   function automatic button_event_type classify_sample(input logic level,
                                                        input logic [TIME_W-1:0] now);
      button_event_type  ev;
      logic [TIME_W-1:0] held;
      logic [TIME_W-1:0] since_release;
      ev.kind  = EV_NONE;
      ev.total = '0;
      // press edge restarts the hold timer and re-arms all tiers
      if (!level && btn_released) begin
         press_t    = now;
         long_seen  = 1'b0;
         extra_seen = 1'b0;
         super_seen = 1'b0;
      end
      // highest tier is tested first, whatever the threshold order
      if (!level) begin
         held = now - press_t;
         if (held > thr.super_hold_ms && !super_seen) begin
            super_seen     = 1'b1;
            extra_seen     = 1'b1;
            long_seen      = 1'b1;
            pending_clicks = 0;
            ev.kind        = EV_SUPER;
         end else if (held > thr.extra_hold_ms && !extra_seen) begin
            extra_seen     = 1'b1;
            long_seen      = 1'b1;
            pending_clicks = 0;
            ev.kind        = EV_EXTRA;
         end else if (held > thr.long_hold_ms && !long_seen) begin
            long_seen      = 1'b1;
            pending_clicks = 0;
            ev.kind        = EV_LONG;
         end
      end
      // release that did not end a long press counts as a click
      if (level && !btn_released && !long_seen) begin
         if (pending_clicks < MAX_CLICKS)
            pending_clicks++;
         release_t = now;
      end
      // quiet time closes the run, even with the button held again
      since_release = now - release_t;
      if (pending_clicks > 0 && since_release > thr.click_gap_ms) begin
         ev.kind        = EV_CLICK;
         ev.total       = pending_clicks[TOTAL_W-1:0];
         pending_clicks = 0;
      end
      btn_released = level;
      return ev;
   endfunction

   // present one request, wait for it to be taken, record its expected event
   task automatic send_sample(input logic level, input logic [TIME_W-1:0] now,
                              input logic typed, input button_event_type typed_ev);
      button_event_type ev;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_button_level <= level;
      req_now_ms       <= now;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      ev = classify_sample(level, now);
      expected_events.push_back(typed ? typed_ev : ev);
      samples_sent++;
      @(negedge clock);
   endtask

   task automatic send_level(input logic level, input logic [TIME_W-1:0] now);
      send_sample(level, now, 1'b0, '0);
   endtask

   // press, a few held samples ending exactly at the hold time, release
   task automatic hold_button(input int unsigned hold);
      int unsigned taps;
      taps = $urandom_range(0, 5);
      send_level(1'b0, stamp_ms);
      for (int j = 1; j <= taps; j++)
         send_level(1'b0, stamp_ms + hold * j / taps);
      stamp_ms += hold;
      send_level(1'b1, stamp_ms);
   endtask

   // released samples spread over the gap, the last one right at its end
   task automatic stay_released(input int unsigned gap);
      int unsigned taps;
      taps = $urandom_range(0, 2);
      for (int j = 1; j <= taps; j++)
         send_level(1'b1, stamp_ms + gap * j / taps);
      stamp_ms += gap;
   endtask

   function automatic int unsigned near_threshold(input logic [THRESH_W-1:0] thresh);
      return $urandom_range((thresh > 2) ? thresh - 2 : 0, thresh + 2);
   endfunction

   // one random stretch of button activity
   task automatic button_episode();
      int unsigned pick;
      int unsigned shortest;
      int unsigned longest;
      int unsigned hold;
      shortest = 32'(thr.long_hold_ms);
      longest  = 32'(thr.long_hold_ms);
      if (thr.extra_hold_ms < shortest) shortest = 32'(thr.extra_hold_ms);
      if (thr.super_hold_ms < shortest) shortest = 32'(thr.super_hold_ms);
      if (thr.extra_hold_ms > longest) longest = 32'(thr.extra_hold_ms);
      if (thr.super_hold_ms > longest) longest = 32'(thr.super_hold_ms);
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         // noise: random level at a random or nearby time
         if ($urandom_range(0, 1) == 1)
            stamp_ms = $urandom;
         else
            stamp_ms += $urandom_range(0, longest + thr.click_gap_ms);
         send_level($urandom_range(0, 1) == 1, stamp_ms);
      end else if (pick < 35) begin
         // click burst, long enough at times to saturate the counter
         repeat ($urandom_range(2, 20)) begin
            hold_button($urandom_range(0, shortest));
            stay_released($urandom_range(0, thr.click_gap_ms));
         end
         stay_released(thr.click_gap_ms + $urandom_range(1, 40));
      end else begin
         // single press aimed at or around one of the tiers
         case ($urandom_range(0, 4))
            0: hold = $urandom_range(0, shortest);
            1: hold = near_threshold(thr.long_hold_ms);
            2: hold = near_threshold(thr.extra_hold_ms);
            3: hold = near_threshold(thr.super_hold_ms);
            default: hold = $urandom_range(0, longest + 100);
         endcase
         hold_button(hold);
         if ($urandom_range(0, 1) == 1)
            stay_released($urandom_range(0, thr.click_gap_ms));
         else
            stay_released(thr.click_gap_ms + $urandom_range(1, 40));
      end
   endtask

   // hold off the sender until every expected event has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_events.size() != 0)
         @(negedge clock);
      // margin after the last response has come back
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [THRESH_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(negedge clock);
   endtask

   task automatic load_thresholds(input cfg_type c);
      write_csr(CSR_LONG_HOLD, c.long_hold_ms);
      write_csr(CSR_EXTRA_HOLD, c.extra_hold_ms);
      write_csr(CSR_SUPER_HOLD, c.super_hold_ms);
      write_csr(CSR_CLICK_GAP, c.click_gap_ms);
      csr_write_enable <= 1'b0;
      thr = c;
   endtask

   // threshold setting for each phase, extremes and out-of-order among them
   function automatic cfg_type pick_thresholds(input int setting);
      cfg_type c;
      c = '{LONG_HOLD_RESET, EXTRA_HOLD_RESET, SUPER_HOLD_RESET, CLICK_GAP_RESET};
      case (setting)
         1: begin
            c.long_hold_ms  = 16'($urandom_range(20, 300));
            c.extra_hold_ms = c.long_hold_ms + 16'($urandom_range(1, 300));
            c.super_hold_ms = c.extra_hold_ms + 16'($urandom_range(1, 300));
            c.click_gap_ms  = 16'($urandom_range(10, 200));
         end
         2: c = '{16'h0000, 16'h0000, 16'h0000, 16'h0000};
         3: c = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
         4: begin
            // tiers reversed: super lowest, long highest
            c.super_hold_ms = 16'($urandom_range(10, 100));
            c.extra_hold_ms = c.super_hold_ms + 16'($urandom_range(10, 200));
            c.long_hold_ms  = c.extra_hold_ms + 16'($urandom_range(10, 200));
            c.click_gap_ms  = 16'($urandom_range(5, 100));
         end
         5: begin
            c.long_hold_ms  = 16'($urandom_range(0, 65535));
            c.extra_hold_ms = 16'($urandom_range(0, 65535));
            c.super_hold_ms = 16'($urandom_range(0, 65535));
            c.click_gap_ms  = 16'($urandom_range(0, 65535));
         end
         6: begin
            c.long_hold_ms  = 16'($urandom_range(0, 8));
            c.extra_hold_ms = 16'($urandom_range(0, 8));
            c.super_hold_ms = 16'($urandom_range(0, 8));
            c.click_gap_ms  = 16'($urandom_range(0, 8));
         end
         default: ;
      endcase
      return c;
   endfunction

   // receiver: random stalls at the rate of the current phase
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // compare each accepted response with the oldest expected event
   always @(posedge clock) begin
      button_event_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_events.size() == 0) begin
            $display("%0t: response with no request pending, kind %0d total %0d",
                     $time, rsp_event_kind, rsp_click_total);
            error_count++;
         end else begin
            want = expected_events.pop_front();
            if (rsp_event_kind !== want.kind) begin
               $display("%0t: event_kind expected %0d actual %0d",
                        $time, want.kind, rsp_event_kind);
               error_count++;
            end
            if (rsp_click_total !== want.total) begin
               $display("%0t: click_total expected %0d actual %0d",
                        $time, want.total, rsp_click_total);
               error_count++;
            end
         end
      end
   end

   // stimulus
   initial begin
      sample_row_type   rows [TABLE_ROWS];
      button_event_type typed_ev;
      // directed walk under the reset thresholds 1000 / 3000 / 4000, gap 300
      rows = '{
         // quiet sample right after reset
         '{1'b1, 32'd0,          1'b1, EV_NONE,  4'd0},
         // press, then climb through all three tiers
         '{1'b0, 32'd100,        1'b1, EV_NONE,  4'd0},
         '{1'b0, 32'd1101,       1'b1, EV_LONG,  4'd0},
         '{1'b0, 32'd3101,       1'b1, EV_EXTRA, 4'd0},
         '{1'b0, 32'd4101,       1'b1, EV_SUPER, 4'd0},
         // release after a long press is not a click
         '{1'b1, 32'd4200,       1'b1, EV_NONE,  4'd0},
         // single click, gap exactly at the limit, then one past it
         '{1'b0, 32'd4300,       1'b1, EV_NONE,  4'd0},
         '{1'b1, 32'd4350,       1'b1, EV_NONE,  4'd0},
         '{1'b1, 32'd4650,       1'b1, EV_NONE,  4'd0},
         '{1'b1, 32'd4651,       1'b1, EV_CLICK, 4'd1},
         // click run closing while the button is held again
         '{1'b0, 32'd5000,       1'b1, EV_NONE,  4'd0},
         '{1'b1, 32'd5010,       1'b1, EV_NONE,  4'd0},
         '{1'b0, 32'd5020,       1'b1, EV_NONE,  4'd0},
         '{1'b0, 32'd5400,       1'b1, EV_CLICK, 4'd1},
         '{1'b1, 32'd5410,       1'b0, EV_NONE,  4'd0},
         // hold across the wrap of the millisecond counter
         '{1'b0, 32'hFFFF_FFF0,  1'b0, EV_NONE,  4'd0},
         '{1'b0, 32'h0000_0400,  1'b0, EV_NONE,  4'd0},
         '{1'b1, 32'hFFFF_FFFF,  1'b0, EV_NONE,  4'd0},
         '{1'b1, 32'd0,          1'b0, EV_NONE,  4'd0}
      };
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int i = 0; i < TABLE_ROWS; i++) begin
         typed_ev.kind  = rows[i].kind;
         typed_ev.total = rows[i].total;
         send_sample(rows[i].level, rows[i].now, rows[i].typed, typed_ev);
      end
      stamp_ms = 32'd10000;
      for (int p = 0; p < PHASE_COUNT; p++) begin
         // idling pattern rotates: none, sender, receiver, both
         case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 47; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 47; end
            default: begin send_idle_pct = 35; stall_pct = 35; end
         endcase
         // thresholds change only with the pipeline empty
         if (p != 0) begin
            wait_drained();
            load_thresholds(pick_thresholds(p));
         end
         // one phase starts just below the counter wrap
         if (p == 5)
            stamp_ms = 32'hFFFF_0000;
         while (samples_sent < TABLE_ROWS + (p + 1) * SAMPLE_TARGET / PHASE_COUNT) begin
            button_episode();
            if ($urandom_range(0, 99) == 0)
               wait_drained();
         end
      end
      req_valid <= 1'b0;
      while (expected_events.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // watchdog against a hung handshake
   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
